// ===== rtl/lpd_pkg.sv =====
// Package for the length-prefixed packet deframer.
// Holds the result kind codes, the result word type and shared constants.
// No dependencies.
package lpd_pkg;

  localparam int unsigned LEN_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HDR_POS_W = 2;

  // Prefix size in bytes; the prefix counts toward the total length.
  localparam logic [LEN_W-1:0] PREFIX_BYTES = 32'd4;
  // Reset value of the maximum accepted packet length.
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd16384;
  // Position of the last prefix byte.
  localparam logic [HDR_POS_W-1:0] HDR_LAST_POS = 2'd3;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_INVALID   = 2'd1,
    KIND_OVERSIZED = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LEN_W-1:0]  packet_length;
    logic              last_of_packet;
    logic              first_of_packet;
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
  } res_t;

endpackage

// ===== rtl/lpd_step.sv =====
// Per-word framing step: header gathering, payload pass and discard state.
// Depends on lpd_pkg. Produces at most one result word per accepted word.
module lpd_step (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      mode,
  input  logic [lpd_pkg::BYTE_W-1:0] byte_in,
  input  logic [lpd_pkg::LEN_W-1:0]  max_len,
  output logic                      res_valid,
  output lpd_pkg::res_t             res
);

  logic [lpd_pkg::HDR_POS_W-1:0] header_bytes_seen, header_bytes_seen_next;
  logic [lpd_pkg::LEN_W-1:0]     length_accumulator, length_accumulator_next;
  logic [lpd_pkg::LEN_W-1:0]     payload_remaining, payload_remaining_next;
  logic                          discarding, discarding_next;
  logic                          at_payload_start, at_payload_start_next;

  logic [lpd_pkg::LEN_W-1:0] hdr_len;
  logic [lpd_pkg::LEN_W-1:0] rem_dec;
  logic                      produce;

  // Full length as it stands once the last prefix byte arrives.
  assign hdr_len = {byte_in, length_accumulator[23:0]};
  assign rem_dec = payload_remaining - 32'd1;

  always_comb begin
    header_bytes_seen_next  = header_bytes_seen;
    length_accumulator_next = length_accumulator;
    payload_remaining_next  = payload_remaining;
    discarding_next         = discarding;
    at_payload_start_next   = at_payload_start;
    produce                 = 1'b0;
    res.kind                = lpd_pkg::KIND_PAYLOAD;
    res.payload_byte        = '0;
    res.first_of_packet     = 1'b0;
    res.last_of_packet      = 1'b0;
    res.packet_length       = length_accumulator;

    if (mode) begin
      // Restart: drop everything gathered so far.
      header_bytes_seen_next  = '0;
      length_accumulator_next = '0;
      payload_remaining_next  = '0;
      discarding_next         = 1'b0;
      at_payload_start_next   = 1'b0;
    end else if (payload_remaining != '0) begin
      payload_remaining_next = rem_dec;
      if (discarding) begin
        if (rem_dec == '0) begin
          discarding_next = 1'b0;
        end
      end else begin
        produce               = 1'b1;
        res.payload_byte      = byte_in;
        res.first_of_packet   = at_payload_start;
        res.last_of_packet    = (payload_remaining == 32'd1);
        at_payload_start_next = 1'b0;
      end
    end else if (header_bytes_seen != lpd_pkg::HDR_LAST_POS) begin
      header_bytes_seen_next = header_bytes_seen + 2'd1;
      case (header_bytes_seen)
        2'd0:    length_accumulator_next = {24'd0, byte_in};
        2'd1:    length_accumulator_next = {16'd0, byte_in, length_accumulator[7:0]};
        2'd2:    length_accumulator_next = {8'd0, byte_in, length_accumulator[15:0]};
        default: length_accumulator_next = length_accumulator;
      endcase
    end else begin
      header_bytes_seen_next  = '0;
      length_accumulator_next = hdr_len;
      res.packet_length       = hdr_len;
      if (hdr_len <= lpd_pkg::PREFIX_BYTES) begin
        produce  = 1'b1;
        res.kind = lpd_pkg::KIND_INVALID;
      end else begin
        payload_remaining_next = hdr_len - lpd_pkg::PREFIX_BYTES;
        if (hdr_len > max_len) begin
          produce               = 1'b1;
          res.kind              = lpd_pkg::KIND_OVERSIZED;
          discarding_next       = 1'b1;
          at_payload_start_next = 1'b0;
        end else begin
          discarding_next       = 1'b0;
          at_payload_start_next = 1'b1;
        end
      end
    end
  end

  assign res_valid = accept & produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes_seen  <= '0;
      length_accumulator <= '0;
      payload_remaining  <= '0;
      discarding         <= 1'b0;
      at_payload_start   <= 1'b0;
    end else if (accept) begin
      header_bytes_seen  <= header_bytes_seen_next;
      length_accumulator <= length_accumulator_next;
      payload_remaining  <= payload_remaining_next;
      discarding         <= discarding_next;
      at_payload_start   <= at_payload_start_next;
    end
  end

  // A partial header only builds while no payload is outstanding.
  assert property (@(posedge clk) disable iff (rst)
    header_bytes_seen != '0 |-> payload_remaining == '0)
    else $error("header gathering overlaps a payload");

  // Discard mode always has bytes left to swallow.
  assert property (@(posedge clk) disable iff (rst)
    discarding |-> payload_remaining != '0)
    else $error("discarding with nothing remaining");

  // A packet being swallowed never marks a first payload byte.
  assert property (@(posedge clk) disable iff (rst)
    at_payload_start |-> !discarding)
    else $error("first mark set on a discarded packet");

endmodule

// ===== rtl/lpd_out_skid.sv =====
// Output register with a skid stage for the deframer result words.
// Depends on lpd_pkg. Keeps the upstream side ready while one result waits.
module lpd_out_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lpd_pkg::res_t in_res,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lpd_pkg::res_t out_res
);

  logic          skid_valid;
  lpd_pkg::res_t skid_res;
  logic          load_out;

  assign in_ready = !skid_valid;
  assign load_out = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_valid) begin
        out_res <= in_res;
      end
    end else if (in_valid) begin
      skid_res <= in_res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while the output is empty");

  assert property (@(posedge clk) disable iff (rst)
    !(in_valid && skid_valid))
    else $error("word arrived while the skid stage was full");

  assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && out_res == $past(skid_res))
    else $error("skid word not moved to the output");

endmodule

// ===== rtl/length_prefixed_packet_deframer.sv =====
// Length-prefixed packet deframer, top level.
// A result word is registered in the output stage (or the skid stage while m_tready is low) before it appears on m_*.
// Throughput: one input word per cycle while s_tready is high; the output register plus a one-word
// skid stage keep s_tready high while a single result waits on m_tready.
// Reset (rst, synchronous): clears header, payload and discard state, empties
// the output; max_packet_length returns to 16384.
// Depends on lpd_pkg, lpd_step and lpd_out_skid.
module length_prefixed_packet_deframer (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration: maximum accepted total packet length.
  input  logic                      cfg_wr_en,
  input  logic [lpd_pkg::LEN_W-1:0] cfg_wr_data,
  // Input stream.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] byte_in
  input  logic                      s_tuser,   // [0] mode (1 = connection restart)
  // Result stream.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [39:0]               m_tdata,   // [7:0] payload_byte, [39:8] packet_length
  output logic [2:0]                m_tuser,   // [1:0] kind, [2] first_of_packet
  output logic                      m_tlast    // last_of_packet
);

  logic [lpd_pkg::LEN_W-1:0] max_packet_length;
  logic                      s_accept;
  logic                      res_valid;
  lpd_pkg::res_t             res;
  lpd_pkg::res_t             out_res;

  // Hold the size limit; the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_length <= lpd_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_packet_length <= cfg_wr_data;
    end
  end

  assign s_accept = s_tvalid && s_tready;

  // Framing state advances on every accepted word; restarts and plain
  // header bytes leave no result.
  lpd_step u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .mode      (s_tuser),
    .byte_in   (s_tdata),
    .max_len   (max_packet_length),
    .res_valid (res_valid),
    .res       (res)
  );

  // Register the result; the skid stage absorbs one word of backpressure.
  lpd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.packet_length, out_res.payload_byte};
  assign m_tuser = {out_res.first_of_packet, out_res.kind};
  assign m_tlast = out_res.last_of_packet;

endmodule
